// ===== design/frc_pkg.sv =====
// Shared types, constants and elaboration-time helpers for the frame rotation core.
// Used by frc_cordic_vec, frc_cordic_rot and frame_rotation_from_approach_axis_core.
// No dependencies.
package frc_pkg;

    // Default parameter values.
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 14;

    // Internal fixed point: Q30 values, angles as 32-bit fractions of a turn.
    localparam int WQ      = 30;
    localparam int TAB_LEN = 30;
    localparam int CW      = 36;   // CORDIC datapath width
    localparam int AW      = 32;   // angle width
    localparam int ZW      = 34;   // signed residual angle width in rotation mode
    localparam int MW      = 34;   // Q30 multiplier operand width
    localparam int RW      = 32;   // rotation matrix entry width
    localparam int FW      = 16;   // input and output field width

    localparam logic [AW-1:0] ANG_HALF = 32'h8000_0000;

    typedef logic signed [CW-1:0] cw_t;
    typedef logic        [AW-1:0] ang_t;
    typedef logic signed [ZW-1:0] zw_t;
    typedef logic signed [MW-1:0] mq_t;
    typedef logic signed [RW-1:0] rq_t;

    // atan(2^-i) as a fraction of a full turn, 2^32 per turn.
    localparam logic [AW-1:0] ATAN_TURN [TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    // Magnitude that the vectoring CORDIC gives for (1.0, 0); used at elaboration only.
    function automatic longint cordic_gain(input int steps);
        longint x;
        longint y;
        longint xs;
        longint ys;
        x = longint'(1) <<< WQ;
        y = 0;
        for (int i = 0; i < TAB_LEN; i++)
        begin
            if (i < steps)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                end
            end
        end
        return x;
    endfunction

    // Q30 product with round-half-up: floor((a * b + 2^29) / 2^30).
    function automatic mq_t mulq(input mq_t a, input mq_t b);
        logic signed [2*MW-1:0] p;
        p = a * b + ((2*MW)'(1) <<< (WQ - 1));
        return p[WQ+MW-1:WQ];
    endfunction

endpackage

// ===== design/frame_rotation_from_approach_axis_core.sv =====
// Frame rotation core: turns an approach vector and a gripper axis vector into a
// 3x3 rotation matrix in Q2.14 (FRAC_BITS fraction bits).
// Depends on frc_pkg, frc_cordic_vec and frc_cordic_rot.
//
// Usage:
//   The input channel (in_valid, in_stall) carries one word: the six signed vector
//   components. The output channel (out_valid, out_stall) carries one word: the
//   nine matrix entries and the approach_on_x flag.
//   Every word passes from acceptance to the output register through six CORDIC
//   pipelines in series (two vectoring for the first rotation, one rotation for its
//   sine and cosine, two vectoring and one rotation for the twist angle) and then
//   through the multiply, normalize and rounding stages.
//   A new word is accepted in every cycle unless in_stall is high; the pipeline
//   holds up to one word per stage at once.
//   When the receiver stalls with a word waiting in the output register, every
//   stage holds and in_stall rises in the same cycle; nothing is lost or repeated.
//   Bubbles in the input stream travel down the pipeline as empty slots.
//   Reset clears all valid bits; the datapath registers are not reset.
module frame_rotation_from_approach_axis_core #(
    parameter int CORDIC_STEPS = frc_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = frc_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [frc_pkg::FW-1:0] approach_x,
    input  logic signed [frc_pkg::FW-1:0] approach_y,
    input  logic signed [frc_pkg::FW-1:0] approach_z,
    input  logic signed [frc_pkg::FW-1:0] axis_x,
    input  logic signed [frc_pkg::FW-1:0] axis_y,
    input  logic signed [frc_pkg::FW-1:0] axis_z,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [frc_pkg::FW-1:0] m00,
    output logic signed [frc_pkg::FW-1:0] m01,
    output logic signed [frc_pkg::FW-1:0] m02,
    output logic signed [frc_pkg::FW-1:0] m10,
    output logic signed [frc_pkg::FW-1:0] m11,
    output logic signed [frc_pkg::FW-1:0] m12,
    output logic signed [frc_pkg::FW-1:0] m20,
    output logic signed [frc_pkg::FW-1:0] m21,
    output logic signed [frc_pkg::FW-1:0] m22,
    output logic                        approach_on_x
);
    import frc_pkg::*;

    // Pipeline geometry.
    localparam int L      = CORDIC_STEPS + 1;
    localparam int LAT    = 6 * L + 13;
    localparam int D_SIDE = 3 * L + 1;
    localparam int D_R    = 3 * L + 7;
    localparam int D_V2   = L + 1;
    localparam int D_SGN  = 2 * L + 1;
    localparam int IN_SH  = 15;
    localparam int VW     = 50;
    localparam int PW     = $clog2(VW);
    localparam int PRW    = RW + FW;
    localparam int EW     = 37;
    localparam int SW     = WQ + EW;
    localparam int SH     = WQ - FRAC_BITS;

    // Gain correction worked out at elaboration.
    localparam longint G_MAG    = cordic_gain(CORDIC_STEPS);
    localparam longint INV_GAIN = (longint'(1) <<< (2 * WQ)) / G_MAG;
    localparam cw_t    INV_CW   = cw_t'(INV_GAIN);
    localparam mq_t    INV_Q    = mq_t'(INV_GAIN);
    localparam mq_t    ONE_Q    = mq_t'(longint'(1) <<< WQ);
    localparam rq_t    ONE_R    = rq_t'(longint'(1) <<< WQ);
    localparam logic signed [SW-1:0] RND_Q = SW'(longint'(1) <<< (WQ - 1));
    localparam logic signed [EW:0]   RND_E = (EW+1)'((longint'(1) <<< SH) >>> 1);
    localparam logic signed [EW:0]   LIM_E = (EW+1)'(longint'(1) <<< FRAC_BITS);

    typedef struct packed {
        logic signed [FW-1:0] wx;
        logic signed [FW-1:0] wy;
        logic signed [FW-1:0] wz;
        logic                 on_x;
        logic                 ax_neg;
    } side_t;

    typedef struct packed {
        logic [2:0][2:0][RW-1:0] e;
        logic                    on_x;
    } rmat_t;

    // Flow control: all stages advance together unless the output word is held.
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en        = !vld_reg[LAT-1] || !out_stall;
    assign in_stall  = !en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // First rotation axis angle: vectoring on (-az, ay).
    cw_t  v1_x;
    cw_t  v1_y;
    ang_t psi;
    cw_t  mag1;

    assign v1_x = -(cw_t'(approach_z) <<< IN_SH);
    assign v1_y = cw_t'(approach_y) <<< IN_SH;

    frc_cordic_vec #(.STEPS(CORDIC_STEPS)) u_vec_psi (
        .clk   (clk),
        .en    (en),
        .x_in  (v1_x),
        .y_in  (v1_y),
        .ang   (psi),
        .mag   (mag1)
    );

    // Side data that rides along to the matrix build.
    side_t side_in;
    side_t side_dly_reg [D_SIDE];
    logic signed [FW-1:0] ax_dly_reg [L+1];

    always_comb
    begin
        side_in.wx     = axis_x;
        side_in.wy     = axis_y;
        side_in.wz     = axis_z;
        side_in.on_x   = (approach_y == '0) && (approach_z == '0);
        side_in.ax_neg = approach_x[FW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dly_reg[0] <= side_in;
            for (int k = 1; k < D_SIDE; k++)
            begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
            ax_dly_reg[0] <= approach_x;
            for (int k = 1; k < L + 1; k++)
            begin
                ax_dly_reg[k] <= ax_dly_reg[k-1];
            end
        end
    end

    // Remove the CORDIC gain from the axis length; register the angle alongside.
    mq_t  rs_reg;
    ang_t psi_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rs_reg  <= mulq(mag1[MW-1:0], INV_Q);
            psi_reg <= psi;
        end
    end

    // Axis direction from psi, and rotation angle from atan2(r, ax), side by side.
    cw_t  uy_c;
    cw_t  uz_c;
    cw_t  v2_x;
    cw_t  v2_y;
    ang_t alpha;

    assign v2_x = cw_t'(ax_dly_reg[L]) <<< IN_SH;
    assign v2_y = cw_t'(rs_reg);

    frc_cordic_rot #(.STEPS(CORDIC_STEPS), .INV_GAIN(INV_CW)) u_rot_psi (
        .clk     (clk),
        .en      (en),
        .ang_in  (psi_reg),
        .cos_out (uy_c),
        .sin_out (uz_c)
    );

    frc_cordic_vec #(.STEPS(CORDIC_STEPS)) u_vec_alpha (
        .clk   (clk),
        .en    (en),
        .x_in  (v2_x),
        .y_in  (v2_y),
        .ang   (alpha),
        .mag   ()
    );

    // Cosine and sine of the first rotation angle; axis components wait for them.
    cw_t cos_a;
    cw_t sin_a;
    rq_t uy_dly_reg [L];
    rq_t uz_dly_reg [L];

    frc_cordic_rot #(.STEPS(CORDIC_STEPS), .INV_GAIN(INV_CW)) u_rot_alpha (
        .clk     (clk),
        .en      (en),
        .ang_in  (alpha),
        .cos_out (cos_a),
        .sin_out (sin_a)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uy_dly_reg[0] <= uy_c[RW-1:0];
            uz_dly_reg[0] <= uz_c[RW-1:0];
            for (int k = 1; k < L; k++)
            begin
                uy_dly_reg[k] <= uy_dly_reg[k-1];
                uz_dly_reg[k] <= uz_dly_reg[k-1];
            end
        end
    end

    // Matrix build, first half: products of the axis components and the sine.
    mq_t   c_r1_reg;
    mq_t   omc_r1_reg;
    mq_t   uyuy_r1_reg;
    mq_t   uyuz_r1_reg;
    mq_t   uzuz_r1_reg;
    mq_t   suy_r1_reg;
    mq_t   suz_r1_reg;
    side_t side_r1_reg;
    mq_t   c_a;
    mq_t   s_a;
    mq_t   uy_a;
    mq_t   uz_a;

    assign c_a  = mq_t'($signed(cos_a[RW-1:0]));
    assign s_a  = mq_t'($signed(sin_a[RW-1:0]));
    assign uy_a = mq_t'(uy_dly_reg[L-1]);
    assign uz_a = mq_t'(uz_dly_reg[L-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_r1_reg    <= c_a;
            omc_r1_reg  <= ONE_Q - c_a;
            uyuy_r1_reg <= mulq(uy_a, uy_a);
            uyuz_r1_reg <= mulq(uy_a, uz_a);
            uzuz_r1_reg <= mulq(uz_a, uz_a);
            suy_r1_reg  <= mulq(s_a, uy_a);
            suz_r1_reg  <= mulq(s_a, uz_a);
            side_r1_reg <= side_dly_reg[D_SIDE-1];
        end
    end

    // Matrix build, second half: Rodrigues terms, or a signed identity on the x axis.
    rmat_t rm_next;
    rmat_t rm_r2_reg;
    logic signed [FW-1:0] w_r2_reg [3];

    always_comb
    begin
        mq_t t11;
        mq_t t12;
        mq_t t22;
        rq_t d;
        t11 = c_r1_reg + mulq(omc_r1_reg, uyuy_r1_reg);
        t12 = mulq(omc_r1_reg, uyuz_r1_reg);
        t22 = c_r1_reg + mulq(omc_r1_reg, uzuz_r1_reg);
        d   = side_r1_reg.ax_neg ? -ONE_R : ONE_R;
        rm_next.on_x = side_r1_reg.on_x;
        if (side_r1_reg.on_x)
        begin
            rm_next.e       = '0;
            rm_next.e[0][0] = d;
            rm_next.e[1][1] = d;
            rm_next.e[2][2] = d;
        end
        else
        begin
            rm_next.e[0][0] = c_r1_reg[RW-1:0];
            rm_next.e[0][1] = rq_t'(-suz_r1_reg);
            rm_next.e[0][2] = suy_r1_reg[RW-1:0];
            rm_next.e[1][0] = suz_r1_reg[RW-1:0];
            rm_next.e[1][1] = t11[RW-1:0];
            rm_next.e[1][2] = t12[RW-1:0];
            rm_next.e[2][0] = rq_t'(-suy_r1_reg);
            rm_next.e[2][1] = t12[RW-1:0];
            rm_next.e[2][2] = t22[RW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rm_r2_reg   <= rm_next;
            w_r2_reg[0] <= side_r1_reg.wx;
            w_r2_reg[1] <= side_r1_reg.wy;
            w_r2_reg[2] <= side_r1_reg.wz;
        end
    end

    // The matrix waits here for the twist angle.
    rmat_t rm_dly_reg [D_R];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rm_dly_reg[0] <= rm_r2_reg;
            for (int k = 1; k < D_R; k++)
            begin
                rm_dly_reg[k] <= rm_dly_reg[k-1];
            end
        end
    end

    // Rotated axis v = R1^T w: products, then column sums.
    logic signed [PRW-1:0] prod_reg [3][3];
    logic signed [VW-1:0]  v_reg    [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= $signed(rm_r2_reg.e[i][j]) * w_r2_reg[i];
                end
            end
            for (int j = 0; j < 3; j++)
            begin
                v_reg[j] <= VW'(prod_reg[0][j]) + VW'(prod_reg[1][j]) + VW'(prod_reg[2][j]);
            end
        end
    end

    // Normalize v so its largest magnitude lies in [2^30, 2^31): abs, max,
    // leading-one search, then one barrel shift.
    logic        [VW-1:0] va_reg  [3];
    logic signed [VW-1:0] vn1_reg [3];
    logic        [VW-1:0] mx_reg;
    logic signed [VW-1:0] vn2_reg [3];
    logic                 left_reg;
    logic        [PW-1:0] amt_reg;
    logic signed [VW-1:0] vn3_reg [3];
    logic signed [RW-1:0] vs_reg  [3];
    logic        [PW-1:0] pos;
    logic        [VW-1:0] mx_next;

    always_comb
    begin
        mx_next = va_reg[0];
        if (va_reg[1] > mx_next)
        begin
            mx_next = va_reg[1];
        end
        if (va_reg[2] > mx_next)
        begin
            mx_next = va_reg[2];
        end
    end

    always_comb
    begin
        pos = '0;
        for (int k = 0; k < VW; k++)
        begin
            if (mx_reg[k])
            begin
                pos = PW'(k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                va_reg[j]  <= v_reg[j][VW-1] ? VW'(-v_reg[j]) : VW'(v_reg[j]);
                vn1_reg[j] <= v_reg[j];
                vn2_reg[j] <= vn1_reg[j];
                vn3_reg[j] <= vn2_reg[j];
            end
            mx_reg   <= mx_next;
            left_reg <= (pos < PW'(WQ));
            amt_reg  <= (pos < PW'(WQ)) ? (PW'(WQ) - pos) : (pos - PW'(WQ));
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [VW-1:0] sh;
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sh = left_reg ? (vn3_reg[j] <<< amt_reg) : (vn3_reg[j] >>> amt_reg);
                vs_reg[j] <= sh[RW-1:0];
            end
        end
    end

    // Twist angle, first part: length of (v0, v1) with the gain removed.
    cw_t  v3_x;
    cw_t  v3_y;
    cw_t  mag3;
    mq_t  mg_reg;
    logic signed [RW-1:0] v2_dly_reg [D_V2];
    logic                 pos_dly_reg [D_SGN];

    assign v3_x = cw_t'(vs_reg[0]);
    assign v3_y = cw_t'(vs_reg[1]);

    frc_cordic_vec #(.STEPS(CORDIC_STEPS)) u_vec_len (
        .clk   (clk),
        .en    (en),
        .x_in  (v3_x),
        .y_in  (v3_y),
        .ang   (),
        .mag   (mag3)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mg_reg         <= mulq(mag3[MW-1:0], INV_Q);
            v2_dly_reg[0]  <= vs_reg[2];
            pos_dly_reg[0] <= !vs_reg[1][RW-1];
            for (int k = 1; k < D_V2; k++)
            begin
                v2_dly_reg[k] <= v2_dly_reg[k-1];
            end
            for (int k = 1; k < D_SGN; k++)
            begin
                pos_dly_reg[k] <= pos_dly_reg[k-1];
            end
        end
    end

    // Twist angle, second part: atan2 of that length against v2, sign from v1.
    cw_t  v4_x;
    cw_t  v4_y;
    ang_t th_raw;
    ang_t th;
    cw_t  cos_t;
    cw_t  sin_t;

    assign v4_x = cw_t'(v2_dly_reg[D_V2-1]);
    assign v4_y = cw_t'(mg_reg);

    frc_cordic_vec #(.STEPS(CORDIC_STEPS)) u_vec_theta (
        .clk   (clk),
        .en    (en),
        .x_in  (v4_x),
        .y_in  (v4_y),
        .ang   (th_raw),
        .mag   ()
    );

    assign th = pos_dly_reg[D_SGN-1] ? (ang_t'(0) - th_raw) : th_raw;

    frc_cordic_rot #(.STEPS(CORDIC_STEPS), .INV_GAIN(INV_CW)) u_rot_theta (
        .clk     (clk),
        .en      (en),
        .ang_in  (th),
        .cos_out (cos_t),
        .sin_out (sin_t)
    );

    // Apply Rx(theta) to columns 1 and 2: products first.
    rmat_t rm_f;
    rq_t   ct;
    rq_t   st;
    logic signed [2*RW-1:0] pa_reg [3];
    logic signed [2*RW-1:0] pb_reg [3];
    logic signed [2*RW-1:0] pc_reg [3];
    logic signed [2*RW-1:0] pd_reg [3];
    rq_t   col0_f1_reg [3];
    logic  on_x_f1_reg;

    assign rm_f = rm_dly_reg[D_R-1];
    assign ct   = cos_t[RW-1:0];
    assign st   = sin_t[RW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i]      <= $signed(rm_f.e[i][1]) * ct;
                pb_reg[i]      <= $signed(rm_f.e[i][2]) * st;
                pc_reg[i]      <= $signed(rm_f.e[i][2]) * ct;
                pd_reg[i]      <= $signed(rm_f.e[i][1]) * st;
                col0_f1_reg[i] <= rm_f.e[i][0];
            end
            on_x_f1_reg <= rm_f.on_x;
        end
    end

    // Sums with Q30 rounding.
    logic signed [EW-1:0] m_f2_reg [3][3];
    logic                 on_x_f2_reg;

    always_ff @(posedge clk)
    begin
        logic signed [SW-1:0] s1;
        logic signed [SW-1:0] s2;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1 = SW'(pa_reg[i]) + SW'(pb_reg[i]) + RND_Q;
                s2 = SW'(pc_reg[i]) - SW'(pd_reg[i]) + RND_Q;
                m_f2_reg[i][0] <= EW'(col0_f1_reg[i]);
                m_f2_reg[i][1] <= s1[SW-1:WQ];
                m_f2_reg[i][2] <= s2[SW-1:WQ];
            end
            on_x_f2_reg <= on_x_f1_reg;
        end
    end

    // Output word: round to FRAC_BITS, saturate to +-1.0, keep the low 16 bits.
    logic [FW-1:0] o_reg [3][3];
    logic          on_x_o_reg;

    always_ff @(posedge clk)
    begin
        logic signed [EW:0] t;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    t = ((EW+1)'(m_f2_reg[i][j]) + RND_E) >>> SH;
                    if (t > LIM_E)
                    begin
                        t = LIM_E;
                    end
                    if (t < -LIM_E)
                    begin
                        t = -LIM_E;
                    end
                    o_reg[i][j] <= t[FW-1:0];
                end
            end
            on_x_o_reg <= on_x_f2_reg;
        end
    end

    assign m00           = o_reg[0][0];
    assign m01           = o_reg[0][1];
    assign m02           = o_reg[0][2];
    assign m10           = o_reg[1][0];
    assign m11           = o_reg[1][1];
    assign m12           = o_reg[1][2];
    assign m20           = o_reg[2][0];
    assign m21           = o_reg[2][1];
    assign m22           = o_reg[2][2];
    assign approach_on_x = on_x_o_reg;

endmodule

// ===== design/frc_cordic_vec.sv =====
// Pipelined CORDIC in vectoring mode: angle and gain-scaled magnitude of (x, y).
// One input register stage for the half-plane fold, then one stage per iteration.
// Depends on frc_pkg.
module frc_cordic_vec #(
    parameter int STEPS = frc_pkg::CORDIC_STEPS_DEF
) (
    input  logic          clk,
    input  logic          en,
    input  frc_pkg::cw_t  x_in,
    input  frc_pkg::cw_t  y_in,
    output frc_pkg::ang_t ang,
    output frc_pkg::cw_t  mag
);
    import frc_pkg::*;

    cw_t  x_reg    [STEPS+1];
    cw_t  y_reg    [STEPS+1];
    ang_t z_reg    [STEPS+1];
    logic zero_reg [STEPS+1];

    // Fold the left half-plane onto the right and note a zero vector.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in[CW-1])
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= ANG_HALF;
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage, driving y toward zero.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TURN[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TURN[i];
                end
            end
        end
    end

    // A zero vector reports angle zero and magnitude zero.
    assign ang = zero_reg[STEPS] ? '0 : z_reg[STEPS];
    assign mag = zero_reg[STEPS] ? '0 : x_reg[STEPS];

endmodule

// ===== design/frc_cordic_rot.sv =====
// Pipelined CORDIC in rotation mode: Q30 cosine and sine of a turn-fraction angle.
// One input register stage for the quadrant fold, then one stage per iteration.
// Depends on frc_pkg.
module frc_cordic_rot #(
    parameter int           STEPS    = frc_pkg::CORDIC_STEPS_DEF,
    parameter frc_pkg::cw_t INV_GAIN = '0
) (
    input  logic          clk,
    input  logic          en,
    input  frc_pkg::ang_t ang_in,
    output frc_pkg::cw_t  cos_out,
    output frc_pkg::cw_t  sin_out
);
    import frc_pkg::*;

    cw_t  x_reg   [STEPS+1];
    cw_t  y_reg   [STEPS+1];
    zw_t  z_reg   [STEPS+1];
    logic neg_reg [STEPS+1];

    logic neg;
    ang_t ang_fold;

    // Angles in the second and third quadrants are turned by half a turn.
    assign neg      = ang_in[AW-1] ^ ang_in[AW-2];
    assign ang_fold = neg ? (ang_in + ANG_HALF) : ang_in;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= neg;
            x_reg[0]   <= INV_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= ZW'($signed(ang_fold));
        end
    end

    // One micro-rotation per stage, driving the residual angle toward zero.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed(ZW'(ATAN_TURN[i]));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed(ZW'(ATAN_TURN[i]));
                end
            end
        end
    end

    // Undo the half-turn fold.
    assign cos_out = neg_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
    assign sin_out = neg_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];

endmodule
